// ===== hw/rtl/tcc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants, types and codes of the text console cursor/scroll core.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLS * ROWS;
    localparam int MOVE_CELLS = (ROWS - 1) * COLS;

    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLS + 1);
    localparam int ADDR_W = $clog2(CELLS);

    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int INCOL_W = 7;
    localparam int INROW_W = 5;
    localparam int ATTR_W  = 8;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [FUNC_W-1:0] FUNC_PUT  = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FUNC_POS  = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FUNC_READ = FUNC_W'(2);

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST    = 8'h7F;

    localparam logic [ATTR_W-1:0] COLOR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0F20;

    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] MOVE_A = ADDR_W'(MOVE_CELLS);

    typedef struct packed {
        logic              do_write;
        logic              do_read;
        logic              do_scroll;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic [ATTR_W-1:0] fill_attr;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage
`default_nettype wire

// ===== hw/rtl/tcc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hw/rtl/tcc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_front
// Front end: holds cursor and color, classifies each word into a command.
// ----------------------------------------------------------------------------
module tcc_front
    import tcc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [FUNC_W-1:0]  i_func,
    input  wire logic [CHAR_W-1:0]  i_char_code,
    input  wire logic [INCOL_W-1:0] i_col,
    input  wire logic [INROW_W-1:0] i_row,
    input  wire logic               i_cfg_we,
    input  wire logic [ATTR_W-1:0]  i_cfg_data,
    output logic                    o_push,
    output t_cmd                    o_cmd
);

    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ATTR_W-1:0] r_color;

    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] new_pos;
    logic              on_screen;
    logic              printable;
    t_cmd              cmd;

    assign cur_addr  = ADDR_W'(r_row) * COLS_A + ADDR_W'(r_col);
    assign in_addr   = ADDR_W'(i_row) * COLS_A + ADDR_W'(i_col);
    assign on_screen = (int'(i_col) < COLS) && (int'(i_row) < ROWS);
    assign printable = (i_char_code >= CH_BLANK) && (i_char_code <= CH_LAST);

    always_comb begin
        n_row         = r_row;
        n_col         = r_col;
        cmd.do_write  = 1'b0;
        cmd.do_read   = 1'b0;
        cmd.do_scroll = 1'b0;
        cmd.addr      = in_addr;
        cmd.data      = {r_color, i_char_code};
        cmd.fill_attr = r_color;
        case (i_func)
            FUNC_PUT: begin
                cmd.addr = cur_addr;
                if (i_char_code == CH_NEWLINE) begin
                    n_row = r_row + ROW_W'(1);
                    n_col = '0;
                end else if (i_char_code == CH_RETURN) begin
                    n_col = '0;
                end else if (printable) begin
                    cmd.do_write = 1'b1;
                    if (r_col == COL_W'(COLS - 1)) begin
                        n_col = '0;
                        n_row = r_row + ROW_W'(1);
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
                if (n_row == ROW_W'(ROWS)) begin
                    cmd.do_scroll = 1'b1;
                    n_row         = ROW_W'(ROWS - 1);
                    n_col         = '0;
                end
            end
            FUNC_POS: begin
                cmd.do_write = on_screen;
            end
            FUNC_READ: begin
                cmd.do_read = on_screen;
            end
            default: begin
            end
        endcase
        new_pos = ADDR_W'(ADDR_W'(n_row) * COLS_A + ADDR_W'(n_col));
        cmd.pos = POS_W'(new_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_color <= COLOR_RESET;
        end else begin
            if (i_accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (i_cfg_we) begin
                r_color <= i_cfg_data;
            end
        end
    end

    assign o_push = i_accept;
    assign o_cmd  = cmd;

endmodule
`default_nettype wire

// ===== hw/rtl/tcc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_queue
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
module tcc_queue
    import tcc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_pop,
    output logic       o_full,
    output t_q_head    o_head
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign do_pop = i_pop && (r_count != '0);

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_full       = (r_count == QCNT_W'(QDEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rptr];

endmodule
`default_nettype wire

// ===== hw/rtl/tcc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_back
// Back end: screen store, clearing pass, cell access, scroll copy and fill.
// ----------------------------------------------------------------------------
module tcc_back
    import tcc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_q_head           i_head,
    output logic                   o_pop,
    output logic                   o_clearing,
    output logic                   o_done,
    output logic      [POS_W-1:0]  o_cursor_pos,
    output logic      [CELL_W-1:0] o_cell_entry
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_READ   = 5'b00100,
        S_SCROLL = 5'b01000,
        S_FILL   = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    t_cmd              r_cmd, n_cmd;
    logic              r_done, n_done;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [CELL_W-1:0] r_cell, n_cell;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic [CELL_W-1:0] rdata;
    logic              pop;

    tcc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_cmd   = r_cmd;
        n_done  = 1'b0;
        n_pos   = r_pos;
        n_cell  = r_cell;
        we      = 1'b0;
        waddr   = r_cnt;
        wdata   = {r_cmd.fill_attr, CH_BLANK};
        raddr   = r_cnt;
        pop     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                wdata = BLANK_CELL;
                if (r_cnt == LAST_A) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                raddr = i_head.cmd.addr;
                if (i_head.valid) begin
                    pop   = 1'b1;
                    n_cmd = i_head.cmd;
                    if (i_head.cmd.do_write) begin
                        we    = 1'b1;
                        waddr = i_head.cmd.addr;
                        wdata = i_head.cmd.data;
                    end
                    if (i_head.cmd.do_read) begin
                        n_state = S_READ;
                    end else if (i_head.cmd.do_scroll) begin
                        n_cnt   = '0;
                        n_state = S_SCROLL;
                    end else begin
                        n_done = 1'b1;
                        n_pos  = i_head.cmd.pos;
                        n_cell = '0;
                    end
                end
            end
            S_READ: begin
                n_done  = 1'b1;
                n_pos   = r_cmd.pos;
                n_cell  = rdata;
                n_state = S_IDLE;
            end
            S_SCROLL: begin
                raddr = r_cnt + COLS_A;
                if (r_cnt != '0) begin
                    we    = 1'b1;
                    waddr = r_cnt - ADDR_W'(1);
                    wdata = rdata;
                end
                if (r_cnt == MOVE_A) begin
                    n_state = S_FILL;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            S_FILL: begin
                we = 1'b1;
                if (r_cnt == LAST_A) begin
                    n_cnt   = '0;
                    n_done  = 1'b1;
                    n_pos   = r_cmd.pos;
                    n_cell  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_pos  <= n_pos;
        r_cell <= n_cell;
    end

    assign o_pop        = pop;
    assign o_clearing   = (r_state == S_CLEAR);
    assign o_done       = r_done;
    assign o_cursor_pos = r_pos;
    assign o_cell_entry = r_cell;

    a_no_done_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_done)
        else $error("result strobe during clearing pass");

    a_scroll_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCROLL) && we && (r_cnt < MOVE_A)) |-> (waddr != raddr))
        else $error("scroll copy reads and writes the same cell");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= LAST_A))
        else $error("sweep counter beyond screen store");

    a_fill_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FILL) && (r_cnt == LAST_A)) |=> r_done)
        else $error("scroll finished without result");

endmodule
`default_nettype wire

// ===== hw/rtl/text_console_cursor_scroll_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core
// Text console engine: screen store of attribute/character cells, cursor,
// newline, carriage return, wrap and scroll, positioned put and cell read.
//
//   channel   direction  handshake              payload
//   command   in         start & !busy          i_func, i_char_code, i_col, i_row
//   result    out        o_done (one cycle)     o_cursor_pos, o_cell_entry
//   color     in         i_text_color_we        i_text_color
//
// after reset busy stays high while the store is cleared
// a read passes through a second back-end state for the registered ram read
// a put that scrolls copies then fills, one cell per cycle
// the result strobe is registered in the back end; a 2-word queue takes words while it works
// busy is high while the queue is full or the store is cleared; the receiver cannot stall results
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core
    import tcc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [FUNC_W-1:0]  i_func,
    input  wire logic [CHAR_W-1:0]  i_char_code,
    input  wire logic [INCOL_W-1:0] i_col,
    input  wire logic [INROW_W-1:0] i_row,
    input  wire logic               i_text_color_we,
    input  wire logic [ATTR_W-1:0]  i_text_color,
    output logic                    o_done,
    output logic      [POS_W-1:0]   o_cursor_pos,
    output logic      [CELL_W-1:0]  o_cell_entry
);

    logic    accept;
    logic    push;
    t_cmd    cmd;
    logic    q_full;
    t_q_head head;
    logic    pop;
    logic    clearing;

    assign busy   = q_full || clearing;
    assign accept = start && !busy;

    tcc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_func      (i_func),
        .i_char_code (i_char_code),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_cfg_we    (i_text_color_we),
        .i_cfg_data  (i_text_color),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    tcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    tcc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_done       (o_done),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_entry (o_cell_entry)
    );

endmodule
`default_nettype wire

// ===== test/text_console_cursor_scroll_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core_tb
// Self-checking bench for the text console core. A queue of command words,
// color writes and drain points feeds a clocked driver. At each accepted
// command the driver steps a mirror of the screen, the cursor and the color
// and queues the expected cursor position and cell. A clocked monitor checks
// each result strobe against the oldest expected result. Directed corner words
// come first, then random phases of text lines, single puts, positioned puts,
// reads and noise, with a new color written between phases.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core_tb;
    import tcc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NOP = FUNC_W'(3);
    localparam int SETTLE_CYCLES = CELLS + 100;
    localparam int PHASES = 6;
    localparam int PHASE_WORDS = 221;

    typedef enum logic [1:0] {WORD_CMD, WORD_COLOR, WORD_DRAIN} t_word_kind;

    typedef struct {
        t_word_kind         kind;
        logic [FUNC_W-1:0]  func;
        logic [CHAR_W-1:0]  ch;
        logic [INCOL_W-1:0] col;
        logic [INROW_W-1:0] row;
        logic [ATTR_W-1:0]  color;
        int                 gap;
    } t_console_word;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] entry;
    } t_console_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [FUNC_W-1:0]  i_func = '0;
    logic [CHAR_W-1:0]  i_char_code = '0;
    logic [INCOL_W-1:0] i_col = '0;
    logic [INROW_W-1:0] i_row = '0;
    logic               i_text_color_we = 1'b0;
    logic [ATTR_W-1:0]  i_text_color = COLOR_RESET;
    logic               o_done;
    logic [POS_W-1:0]   o_cursor_pos;
    logic [CELL_W-1:0]  o_cell_entry;

    t_console_word   word_q[$];
    t_console_result cursor_cell_q[$];

    logic [CELL_W-1:0] screen_mirror [CELLS];
    int                mirror_row;
    int                mirror_col;
    logic [ATTR_W-1:0] mirror_color;

    int wait_cnt = 0;
    int mismatch_cnt = 0;
    int cmd_cnt = 0;
    bit calm = 1'b0;

    text_console_cursor_scroll_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_char_code     (i_char_code),
        .i_col           (i_col),
        .i_row           (i_row),
        .i_text_color_we (i_text_color_we),
        .i_text_color    (i_text_color),
        .o_done          (o_done),
        .o_cursor_pos    (o_cursor_pos),
        .o_cell_entry    (o_cell_entry)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_console_result console_step(
        input logic [FUNC_W-1:0]  func,
        input logic [CHAR_W-1:0]  ch,
        input logic [INCOL_W-1:0] col,
        input logic [INROW_W-1:0] row
    );
        t_console_result res;
        bit              on_screen;
        int              addr;
        res.entry = '0;
        on_screen = (col < COLS) && (row < ROWS);
        addr = int'(row) * COLS + int'(col);
        case (func)
            FUNC_PUT: begin
                if (ch == CH_NEWLINE) begin
                    mirror_row++;
                    mirror_col = 0;
                end else if (ch == CH_RETURN) begin
                    mirror_col = 0;
                end else if (ch >= CH_BLANK && ch <= CH_LAST) begin
                    screen_mirror[mirror_row * COLS + mirror_col] = {mirror_color, ch};
                    mirror_col++;
                    if (mirror_col >= COLS) begin
                        mirror_col = 0;
                        mirror_row++;
                    end
                end
                if (mirror_row >= ROWS) begin
                    for (int i = 0; i < MOVE_CELLS; i++) begin
                        screen_mirror[i] = screen_mirror[i + COLS];
                    end
                    for (int i = MOVE_CELLS; i < CELLS; i++) begin
                        screen_mirror[i] = {mirror_color, CH_BLANK};
                    end
                    mirror_row = ROWS - 1;
                    mirror_col = 0;
                end
            end
            FUNC_POS: begin
                if (on_screen) screen_mirror[addr] = {mirror_color, ch};
            end
            FUNC_READ: begin
                if (on_screen) res.entry = screen_mirror[addr];
            end
            default: ;
        endcase
        res.pos = POS_W'(mirror_row * COLS + mirror_col);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    task automatic queue_word(
        input t_word_kind         kind,
        input logic [FUNC_W-1:0]  func,
        input logic [CHAR_W-1:0]  ch,
        input logic [INCOL_W-1:0] col,
        input logic [INROW_W-1:0] row,
        input logic [ATTR_W-1:0]  color
    );
        t_console_word w;
        w.kind = kind;
        w.func = func;
        w.ch = ch;
        w.col = col;
        w.row = row;
        w.color = color;
        w.gap = pick_gap();
        word_q.push_back(w);
    endtask

    task automatic queue_cmd(
        input logic [FUNC_W-1:0]  func,
        input logic [CHAR_W-1:0]  ch,
        input logic [INCOL_W-1:0] col,
        input logic [INROW_W-1:0] row
    );
        queue_word(WORD_CMD, func, ch, col, row, '0);
        cmd_cnt++;
    endtask

    task automatic pick_coord(output logic [INCOL_W-1:0] col, output logic [INROW_W-1:0] row);
        if ($urandom_range(0, 99) < 85) begin
            col = INCOL_W'($urandom_range(0, COLS - 1));
            row = INROW_W'($urandom_range(0, ROWS - 1));
        end else begin
            col = INCOL_W'($urandom);
            row = INROW_W'($urandom);
        end
    endtask

    // driver
    always @(posedge i_clk) begin : driver_proc
        logic          nxt_start;
        logic          nxt_we;
        t_console_word w;
        nxt_start = start;
        nxt_we = 1'b0;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
            for (int i = 0; i < CELLS; i++) begin
                screen_mirror[i] = BLANK_CELL;
            end
            mirror_row = 0;
            mirror_col = 0;
            mirror_color = COLOR_RESET;
            wait_cnt = 0;
        end else begin
            if (start && !busy) begin
                cursor_cell_q.push_back(console_step(i_func, i_char_code, i_col, i_row));
                nxt_start = 1'b0;
            end
            if (!nxt_start && word_q.size() > 0) begin
                w = word_q[0];
                case (w.kind)
                    WORD_CMD: begin
                        if (wait_cnt < w.gap) begin
                            wait_cnt++;
                        end else begin
                            i_func <= w.func;
                            i_char_code <= w.ch;
                            i_col <= w.col;
                            i_row <= w.row;
                            nxt_start = 1'b1;
                            void'(word_q.pop_front());
                            wait_cnt = 0;
                        end
                    end
                    WORD_COLOR: begin
                        if (cursor_cell_q.size() != 0 || busy) begin
                            wait_cnt = 0;
                        end else if (wait_cnt < SETTLE_CYCLES) begin
                            wait_cnt++;
                        end else begin
                            i_text_color <= w.color;
                            mirror_color = w.color;
                            nxt_we = 1'b1;
                            void'(word_q.pop_front());
                            wait_cnt = 0;
                        end
                    end
                    default: begin
                        if (cursor_cell_q.size() == 0) begin
                            void'(word_q.pop_front());
                            wait_cnt = 0;
                        end
                    end
                endcase
            end
        end
        start <= nxt_start;
        i_text_color_we <= nxt_we;
    end

    // monitor
    always @(posedge i_clk) begin : monitor_proc
        t_console_result exp_r;
        if (i_rst_n && o_done) begin
            if (cursor_cell_q.size() == 0) begin
                $error("unexpected word: cursor_pos %0d cell_entry %h", o_cursor_pos,
                       o_cell_entry);
                mismatch_cnt++;
            end else begin
                exp_r = cursor_cell_q.pop_front();
                if (o_cursor_pos !== exp_r.pos) begin
                    $error("cursor_pos: expected %0d, actual %0d", exp_r.pos, o_cursor_pos);
                    mismatch_cnt++;
                end
                if (o_cell_entry !== exp_r.entry) begin
                    $error("cell_entry: expected %h, actual %h", exp_r.entry, o_cell_entry);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin : stimulus_proc
        logic [INCOL_W-1:0] col;
        logic [INROW_W-1:0] row;
        logic [ATTR_W-1:0]  color;
        int                 r;
        int                 s;
        int                 len;
        int                 phase_end;
        bit                 drained;

        // directed corners
        queue_word(WORD_COLOR, FUNC_PUT, '0, '0, '0, COLOR_RESET);
        queue_cmd(FUNC_PUT, 8'h48, 7'd5, 5'd3);
        queue_cmd(FUNC_PUT, CH_BLANK, 7'd0, 5'd0);
        queue_cmd(FUNC_PUT, CH_LAST, 7'd127, 5'd31);
        queue_cmd(FUNC_PUT, 8'h1F, 7'd0, 5'd0);
        queue_cmd(FUNC_PUT, 8'h80, 7'd0, 5'd0);
        queue_cmd(FUNC_PUT, 8'hFF, 7'd0, 5'd0);
        queue_cmd(FUNC_PUT, 8'h00, 7'd0, 5'd0);
        queue_cmd(FUNC_PUT, CH_RETURN, 7'd0, 5'd0);
        queue_cmd(FUNC_PUT, CH_NEWLINE, 7'd0, 5'd0);
        queue_cmd(FUNC_POS, 8'h5A, 7'd0, 5'd0);
        queue_cmd(FUNC_POS, 8'hFF, 7'(COLS - 1), 5'(ROWS - 1));
        queue_cmd(FUNC_POS, 8'h41, 7'(COLS), 5'd0);
        queue_cmd(FUNC_POS, 8'h42, 7'd0, 5'(ROWS));
        queue_cmd(FUNC_POS, 8'h00, 7'd127, 5'd31);
        queue_cmd(FUNC_POS, 8'h80, 7'(COLS - 1), 5'd0);
        queue_cmd(FUNC_READ, 8'hFF, 7'd0, 5'd0);
        queue_cmd(FUNC_READ, 8'h00, 7'd1, 5'd0);
        queue_cmd(FUNC_READ, 8'h00, 7'(COLS - 1), 5'd0);
        queue_cmd(FUNC_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 1));
        queue_cmd(FUNC_READ, 8'h00, 7'(COLS), 5'd0);
        queue_cmd(FUNC_READ, 8'h00, 7'd0, 5'(ROWS));
        queue_cmd(FUNC_READ, 8'h00, 7'd127, 5'd31);
        queue_cmd(FUNC_NOP, 8'h41, 7'd2, 5'd1);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: color = 8'h00;
                1: color = 8'hFF;
                2: color = 8'h1E;
                4: color = 8'h70;
                default: color = ATTR_W'($urandom);
            endcase
            queue_word(WORD_COLOR, FUNC_PUT, '0, '0, '0, color);
            phase_end = cmd_cnt + PHASE_WORDS;
            drained = 1'b0;
            while (cmd_cnt < phase_end) begin
                if ($urandom_range(0, 19) == 0) calm = !calm;
                if (!drained && cmd_cnt > phase_end - PHASE_WORDS / 2) begin
                    queue_word(WORD_DRAIN, FUNC_PUT, '0, '0, '0, '0);
                    drained = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    // a line of text
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
                                                      : $urandom_range(1, 30);
                    for (int k = 0; k < len; k++) begin
                        queue_cmd(FUNC_PUT, CHAR_W'($urandom_range(CH_BLANK, CH_LAST)),
                                  INCOL_W'($urandom), INROW_W'($urandom));
                    end
                    s = $urandom_range(0, 99);
                    if (s < 70) begin
                        if (s >= 50) queue_cmd(FUNC_PUT, CH_RETURN, INCOL_W'($urandom),
                                               INROW_W'($urandom));
                        queue_cmd(FUNC_PUT, CH_NEWLINE, INCOL_W'($urandom),
                                  INROW_W'($urandom));
                    end
                end else if (r < 40) begin
                    s = $urandom_range(0, 99);
                    queue_cmd(FUNC_PUT,
                              (s < 8)  ? CH_NEWLINE :
                              (s < 12) ? CH_RETURN :
                              (s < 75) ? CHAR_W'($urandom_range(CH_BLANK, CH_LAST))
                                       : CHAR_W'($urandom),
                              INCOL_W'($urandom), INROW_W'($urandom));
                end else if (r < 62) begin
                    pick_coord(col, row);
                    queue_cmd(FUNC_POS, CHAR_W'($urandom), col, row);
                end else if (r < 94) begin
                    pick_coord(col, row);
                    queue_cmd(FUNC_READ, CHAR_W'($urandom), col, row);
                end else begin
                    queue_cmd(FUNC_W'($urandom), CHAR_W'($urandom), INCOL_W'($urandom),
                              INROW_W'($urandom));
                end
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_q.size() != 0 || start || cursor_cell_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && cursor_cell_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #200_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
